[rtl/top_k_min_heap_selector_top_defines.svh]
// Assertion macros shared by the top k min-heap selector RTL.
`ifndef TOP_K_MIN_HEAP_SELECTOR_TOP_DEFINES_SVH
`define TOP_K_MIN_HEAP_SELECTOR_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define TKHS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define TKHS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/tkhs_pkg.sv]
// Shared types and constants of the top k min-heap selector.
package tkhs_pkg;

   localparam int HEAP_SIZE_DEF = 16;
   localparam int WEIGHT_W      = 32;
   localparam int ID_W          = 32;

   localparam logic signed [WEIGHT_W-1:0] W_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DRAIN  = 2'd1
   } op_type;

   typedef struct packed {
      logic signed [WEIGHT_W-1:0] weight;
      logic [ID_W-1:0]            id;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_CHK,
      S_INS_RDL,
      S_INS_RDR,
      S_INS_PICK,
      S_INS_MOVE,
      S_INS_PLACE,
      S_DRN_SCAN,
      S_DRN_EMIT
   } state_type;

endpackage

[rtl/top_k_min_heap_selector_top.sv]
// Top level of the top k min-heap selector: sequencer, shared compare, slot store.
//
// Keeps the HEAP_SIZE heaviest (weight, item id) words seen, as a binary min-heap
// whose root is the lightest kept word.
// Input channel: drive req_op, req_weight, req_item_id with start high; a word is
// taken at a rising edge where start is high and busy is low.
//   req_op = insert: a weight not above the root is dropped; otherwise it
//   replaces the root and sifts down. Each heap level costs two RAM reads (left
//   and right child) on the one read port and two passes through the single
//   signed comparator.
//   req_op = drain: emits all HEAP_SIZE slots heaviest first, equal weights in
//   ascending slot order, then clears the store. Each word takes one scan over the
//   RAM and then one emit state, in which it is output.
// Result channel: rsp_strobe marks each drain word for exactly one cycle; rsp_last
// flags the final one. The receiver cannot stall; busy stays high until done.
// Empty slots leave with rsp_valid_entry low, the most negative weight and id zero.
// Reset (synchronous, active high) empties every slot at once through the valid
// flags; the RAM itself needs no clearing pass.
`include "top_k_min_heap_selector_top_defines.svh"

module top_k_min_heap_selector_top #(
   parameter int HEAP_SIZE = tkhs_pkg::HEAP_SIZE_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_op,
   input  logic signed [tkhs_pkg::WEIGHT_W-1:0] req_weight,
   input  logic        [tkhs_pkg::ID_W-1:0]     req_item_id,
   output logic                                 rsp_strobe,
   output logic                                 rsp_valid_entry,
   output logic signed [tkhs_pkg::WEIGHT_W-1:0] rsp_out_weight,
   output logic        [tkhs_pkg::ID_W-1:0]     rsp_out_id,
   output logic                                 rsp_last
);

   import tkhs_pkg::*;

   localparam int AW = $clog2(HEAP_SIZE);
   localparam int CW = AW + 2;   // child index, wide enough for 2*p+2

   function automatic logic [CW-1:0] left_of(input logic [AW-1:0] p);
      left_of = ({2'b00, p} << 1) + CW'(1);
   endfunction

   // sequencer
   state_type state_ff, state_in;

   // candidate and hole position during sift-down
   logic signed [WEIGHT_W-1:0] cand_w_ff, cand_w_in;
   logic [ID_W-1:0]            cand_id_ff, cand_id_in;
   logic [AW-1:0]              pos_ff, pos_in;

   // lighter child under test
   logic signed [WEIGHT_W-1:0] child_w_ff, child_w_in;
   logic [ID_W-1:0]            child_id_ff, child_id_in;
   logic                       child_v_ff, child_v_in;
   logic [AW-1:0]              child_idx_ff, child_idx_in;

   // drain selection
   logic [AW:0]                sc_ff, sc_in;
   logic                       have_ff, have_in;
   logic signed [WEIGHT_W-1:0] best_w_ff, best_w_in;
   logic [ID_W-1:0]            best_id_ff, best_id_in;
   logic                       best_v_ff, best_v_in;
   logic [AW-1:0]              best_idx_ff, best_idx_in;
   logic [AW-1:0]              out_cnt_ff, out_cnt_in;
   logic [HEAP_SIZE-1:0]       done_ff, done_in;

   // per-slot occupancy; a clear slot reads as the most negative weight and id zero
   logic [HEAP_SIZE-1:0]       slot_valid_ff, slot_valid_in;

   // slot store
   logic                       wr_en;
   slot_type                   wr_data;
   logic [AW-1:0]              rd_addr;
   logic [AW-1:0]              rd_idx_ff;
   slot_type                   rd_data;

   logic signed [WEIGHT_W-1:0] eff_rd_w;
   logic [ID_W-1:0]            eff_rd_id;
   logic                       rd_valid;

   // shared signed comparator
   logic signed [WEIGHT_W-1:0] cmp_a, cmp_b;
   logic                       cmp_lt;

   logic [CW-1:0]              lidx, ridx;
   logic                       l_has, r_has, child_l_has;
   logic                       drain_last;

   tkhs_ram #(
      .WIDTH(SLOT_W),
      .DEPTH(HEAP_SIZE)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(pos_ff),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign lidx        = left_of(pos_ff);
   assign ridx        = lidx + CW'(1);
   assign l_has       = lidx < CW'(HEAP_SIZE);
   assign r_has       = ridx < CW'(HEAP_SIZE);
   assign child_l_has = left_of(child_idx_ff) < CW'(HEAP_SIZE);
   assign drain_last  = out_cnt_ff == AW'(HEAP_SIZE - 1);

   // mask the raw RAM word with the slot's valid flag
   assign rd_valid  = slot_valid_ff[rd_idx_ff];
   assign eff_rd_w  = rd_valid ? rd_data.weight : W_MIN;
   assign eff_rd_id = rd_valid ? rd_data.id : '0;

   assign cmp_lt = cmp_a < cmp_b;

   assign busy            = state_ff != S_IDLE;
   assign rsp_valid_entry = best_v_ff;
   assign rsp_out_weight  = best_w_ff;
   assign rsp_out_id      = best_id_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = (req_op == OP_DRAIN[0]) ? S_DRN_SCAN : S_INS_CHK;
            end
         end
         S_INS_CHK: begin
            // root < candidate: take the root's place, else drop
            if (cmp_lt) begin
               state_in = l_has ? S_INS_RDL : S_INS_PLACE;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_INS_RDL:  state_in = S_INS_RDR;
         S_INS_RDR:  state_in = S_INS_PICK;
         S_INS_PICK: state_in = S_INS_MOVE;
         S_INS_MOVE: begin
            if (cmp_lt && child_l_has) begin
               state_in = S_INS_RDL;
            end else begin
               state_in = S_INS_PLACE;
            end
         end
         S_INS_PLACE: state_in = S_IDLE;
         S_DRN_SCAN: begin
            if (sc_ff == (AW+1)'(HEAP_SIZE)) begin
               state_in = S_DRN_EMIT;
            end
         end
         S_DRN_EMIT: state_in = drain_last ? S_IDLE : S_DRN_SCAN;
         default:    state_in = S_IDLE;
      endcase
   end

   // outputs: RAM controls, comparator operands, result strobe
   always_comb begin
      rd_addr    = '0;
      wr_en      = 1'b0;
      wr_data    = '{weight: cand_w_ff, id: cand_id_ff};
      cmp_a      = eff_rd_w;
      cmp_b      = cand_w_ff;
      rsp_strobe = 1'b0;
      rsp_last   = 1'b0;
      case (state_ff)
         S_IDLE:    rd_addr = '0;   // root word ready for the check
         S_INS_CHK: rd_addr = '0;
         S_INS_RDL: rd_addr = lidx[AW-1:0];
         S_INS_RDR: rd_addr = ridx[AW-1:0];
         S_INS_PICK: begin
            cmp_a = eff_rd_w;
            cmp_b = child_w_ff;
         end
         S_INS_MOVE: begin
            // lift the child into the hole; a stop overwrites it in PLACE
            cmp_a   = child_w_ff;
            cmp_b   = cand_w_ff;
            wr_en   = 1'b1;
            wr_data = '{weight: child_w_ff, id: child_id_ff};
         end
         S_INS_PLACE: wr_en = 1'b1;
         S_DRN_SCAN: begin
            rd_addr = sc_ff[AW-1:0];
            cmp_a   = best_w_ff;
            cmp_b   = eff_rd_w;
         end
         S_DRN_EMIT: begin
            rsp_strobe = 1'b1;
            rsp_last   = drain_last;
         end
         default: rd_addr = '0;
      endcase
   end

   // datapath next values
   always_comb begin
      cand_w_in     = cand_w_ff;
      cand_id_in    = cand_id_ff;
      pos_in        = pos_ff;
      child_w_in    = child_w_ff;
      child_id_in   = child_id_ff;
      child_v_in    = child_v_ff;
      child_idx_in  = child_idx_ff;
      sc_in         = sc_ff;
      have_in       = have_ff;
      best_w_in     = best_w_ff;
      best_id_in    = best_id_ff;
      best_v_in     = best_v_ff;
      best_idx_in   = best_idx_ff;
      out_cnt_in    = out_cnt_ff;
      done_in       = done_ff;
      slot_valid_in = slot_valid_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cand_w_in  = req_weight;
               cand_id_in = req_item_id;
               pos_in     = '0;
               sc_in      = '0;
               have_in    = 1'b0;
            end
         end
         S_INS_RDR: begin
            // left child word arrives
            child_w_in   = eff_rd_w;
            child_id_in  = eff_rd_id;
            child_v_in   = rd_valid;
            child_idx_in = lidx[AW-1:0];
         end
         S_INS_PICK: begin
            // right child wins only when strictly lighter
            if (r_has && cmp_lt) begin
               child_w_in   = eff_rd_w;
               child_id_in  = eff_rd_id;
               child_v_in   = rd_valid;
               child_idx_in = ridx[AW-1:0];
            end
         end
         S_INS_MOVE: begin
            if (cmp_lt) begin
               slot_valid_in[pos_ff] = child_v_ff;
               pos_in                = child_idx_ff;
            end
         end
         S_INS_PLACE: slot_valid_in[pos_ff] = 1'b1;
         S_DRN_SCAN: begin
            // first hit of the heaviest weight keeps ties in slot order
            if (sc_ff != '0 && !done_ff[rd_idx_ff] && (!have_ff || cmp_lt)) begin
               have_in     = 1'b1;
               best_w_in   = eff_rd_w;
               best_id_in  = eff_rd_id;
               best_v_in   = rd_valid;
               best_idx_in = rd_idx_ff;
            end
            sc_in = sc_ff + (AW+1)'(1);
         end
         S_DRN_EMIT: begin
            done_in[best_idx_ff] = 1'b1;
            if (drain_last) begin
               slot_valid_in = '0;
               done_in       = '0;
               out_cnt_in    = '0;
            end else begin
               out_cnt_in = out_cnt_ff + AW'(1);
            end
            sc_in   = '0;
            have_in = 1'b0;
         end
         default: have_in = have_ff;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         slot_valid_ff <= '0;
         done_ff       <= '0;
         out_cnt_ff    <= '0;
         sc_ff         <= '0;
         have_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_valid_ff <= slot_valid_in;
         done_ff       <= done_in;
         out_cnt_ff    <= out_cnt_in;
         sc_ff         <= sc_in;
         have_ff       <= have_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cand_w_ff    <= cand_w_in;
      cand_id_ff   <= cand_id_in;
      pos_ff       <= pos_in;
      child_w_ff   <= child_w_in;
      child_id_ff  <= child_id_in;
      child_v_ff   <= child_v_in;
      child_idx_ff <= child_idx_in;
      best_w_ff    <= best_w_in;
      best_id_ff   <= best_id_in;
      best_v_ff    <= best_v_in;
      best_idx_ff  <= best_idx_in;
      rd_idx_ff    <= rd_addr;
   end

   `TKHS_ASSERT_SAME(a_strobe_busy, clock, reset, rsp_strobe, busy && (state_ff == S_DRN_EMIT), "result strobe outside a drain emit")
   `TKHS_ASSERT_NEXT(a_insert_silent, clock, reset, start && !busy && (req_op == OP_INSERT[0]), !rsp_strobe, "insert produced a result")
   `TKHS_ASSERT_NEXT(a_drain_clears, clock, reset, rsp_strobe && rsp_last, (slot_valid_ff == '0) && (done_ff == '0) && !busy, "store not cleared after drain")
   `TKHS_ASSERT_SAME(a_emit_count, clock, reset, 1'b1, $countones(done_ff) == int'(out_cnt_ff), "emitted slot count mismatch")

endmodule

[rtl/tkhs_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module tkhs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
